// File: hw/rtl/iq_frequency_shifter_defines.svh
// assertion macros for the iq frequency shifter
// included by modules that carry concurrent checks; needs clk and arst_n in scope
`ifndef IQ_FREQUENCY_SHIFTER_DEFINES_SVH
`define IQ_FREQUENCY_SHIFTER_DEFINES_SVH

// same-cycle implication
`define IQFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iqfs same-cycle check failed");

// next-cycle implication
`define IQFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iqfs next-cycle check failed");

`endif

// File: hw/rtl/iqfs_pkg.sv
// shared types and constants of the iq frequency shifter
// used by iqfs_ctrl, iqfs_datapath and iq_frequency_shifter; no dependencies
`default_nettype none

package iqfs_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int OSC_WIDTH_DEF    = 18;
	localparam int CFG_INDEX_WIDTH  = 4;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_COS   = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_SIN   = CFG_INDEX_WIDTH'(1);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_UP   = CFG_INDEX_WIDTH'(2);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUARTER_FS = CFG_INDEX_WIDTH'(3);

	typedef enum logic [3:0] {
		MUL_OQ_C,
		MUL_OI_S,
		MUL_OI_C,
		MUL_OQ_S,
		MUL_RQ_NQ,
		MUL_RI_NI,
		MUL_RI_NQ,
		MUL_RQ_NI,
		MUL_NQ_NQ,
		MUL_NI_NI,
		MUL_G_NQ,
		MUL_G_NI
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB,
		ACC_C3_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_NQ,
		WB_NI,
		WB_OUTQ,
		WB_OUTI,
		WB_GAIN,
		WB_OSCQ,
		WB_OSCI
	} wb_sel_t;

	typedef struct packed {
		logic     take;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		wb_sel_t  wb_sel;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic quarter_mode;
		logic last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/iqfs_datapath.sv
// datapath: config registers, oscillator, shared multiplier, accumulator,
// rounding/saturation and output register; depends on iqfs_pkg
`default_nettype none

module iqfs_datapath
	import iqfs_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int OSC_WIDTH    = OSC_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ctrl_cmd_t                         cmd,
	output dp_status_t                             status,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_i,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_q,
	input  wire logic                              last_in_block,
	input  wire logic                              cfg_we,
	input  wire logic        [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic        [OSC_WIDTH-1:0]       cfg_data,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic signed [SAMPLE_WIDTH-1:0]         out_i,
	output logic signed [SAMPLE_WIDTH-1:0]         out_q
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int OW = OSC_WIDTH;
	localparam int F  = OW - 2;
	localparam int MW = (SW > OW) ? SW : OW;
	localparam int PW = 2 * MW;
	localparam int AW = PW + 2;

	localparam logic signed [OW-1:0] OSC_ONE  = OW'(1) <<< F;
	localparam logic signed [AW-1:0] HALF_F   = AW'(1) <<< (F - 1);
	localparam logic signed [AW-1:0] HALF_G   = AW'(1) <<< F;
	localparam logic signed [AW-1:0] C3       = AW'(3) <<< (2 * F);
	localparam logic signed [AW-1:0] OSC_MAX  = AW'(signed'({1'b0, {(OW-1){1'b1}}}));
	localparam logic signed [AW-1:0] OSC_MIN  = AW'(signed'({1'b1, {(OW-1){1'b0}}}));
	localparam logic signed [AW-1:0] SMP_MAXW = AW'(signed'({1'b0, {(SW-1){1'b1}}}));
	localparam logic signed [AW-1:0] SMP_MINW = AW'(signed'({1'b1, {(SW-1){1'b0}}}));
	localparam logic signed [SW-1:0] SMP_MAX  = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMP_MIN  = {1'b1, {(SW-1){1'b0}}};

	// control state
	logic signed [OW-1:0] step_cos_q, step_sin_q;
	logic                 shift_up_q, quarter_q;
	logic signed [OW-1:0] osc_i_q, osc_q_q;
	logic [1:0]           qph_q;
	logic                 m_tvalid_q;

	// payload
	logic                 last_q;
	logic signed [SW-1:0] ri_q, rq_q;
	logic signed [OW-1:0] nq_q, ni_q, g_q;
	logic signed [PW-1:0] p_q;
	logic signed [AW-1:0] acc_q;
	logic signed [SW-1:0] res_i_q, res_q_q;
	logic signed [SW-1:0] out_i_q, out_q_q;

	logic signed [SW-1:0] ri_in, rq_in, neg_ri, neg_rq, q_ni, q_nq;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [AW-1:0] rnd_f, rnd_g;
	logic signed [OW-1:0] sat_osc, sat_gain;
	logic signed [SW-1:0] sat_smp;

	// role swap and quarter-rate rotation
	always_comb begin
		ri_in  = shift_up_q ? sample_i : sample_q;
		rq_in  = shift_up_q ? sample_q : sample_i;
		neg_ri = (ri_in == SMP_MIN) ? SMP_MAX : -ri_in;
		neg_rq = (rq_in == SMP_MIN) ? SMP_MAX : -rq_in;
		unique case (qph_q)
			2'd0: begin
				q_ni = ri_in;
				q_nq = rq_in;
			end
			2'd1: begin
				q_ni = rq_in;
				q_nq = neg_ri;
			end
			2'd2: begin
				q_ni = neg_ri;
				q_nq = neg_rq;
			end
			default: begin
				q_ni = neg_rq;
				q_nq = ri_in;
			end
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_OQ_C: begin
				mul_a = MW'(osc_q_q);
				mul_b = MW'(step_cos_q);
			end
			MUL_OI_S: begin
				mul_a = MW'(osc_i_q);
				mul_b = MW'(step_sin_q);
			end
			MUL_OI_C: begin
				mul_a = MW'(osc_i_q);
				mul_b = MW'(step_cos_q);
			end
			MUL_OQ_S: begin
				mul_a = MW'(osc_q_q);
				mul_b = MW'(step_sin_q);
			end
			MUL_RQ_NQ: begin
				mul_a = MW'(rq_q);
				mul_b = MW'(nq_q);
			end
			MUL_RI_NI: begin
				mul_a = MW'(ri_q);
				mul_b = MW'(ni_q);
			end
			MUL_RI_NQ: begin
				mul_a = MW'(ri_q);
				mul_b = MW'(nq_q);
			end
			MUL_RQ_NI: begin
				mul_a = MW'(rq_q);
				mul_b = MW'(ni_q);
			end
			MUL_NQ_NQ: begin
				mul_a = MW'(nq_q);
				mul_b = MW'(nq_q);
			end
			MUL_NI_NI: begin
				mul_a = MW'(ni_q);
				mul_b = MW'(ni_q);
			end
			MUL_G_NQ: begin
				mul_a = MW'(g_q);
				mul_b = MW'(nq_q);
			end
			MUL_G_NI: begin
				mul_a = MW'(g_q);
				mul_b = MW'(ni_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round half up, then saturate
	always_comb begin
		rnd_f = (acc_q + HALF_F) >>> F;
		rnd_g = (acc_q + HALF_G) >>> (F + 1);
		if (rnd_f > OSC_MAX) begin
			sat_osc = OSC_MAX[OW-1:0];
		end else if (rnd_f < OSC_MIN) begin
			sat_osc = OSC_MIN[OW-1:0];
		end else begin
			sat_osc = rnd_f[OW-1:0];
		end
		if (rnd_g > OSC_MAX) begin
			sat_gain = OSC_MAX[OW-1:0];
		end else if (rnd_g < OSC_MIN) begin
			sat_gain = OSC_MIN[OW-1:0];
		end else begin
			sat_gain = rnd_g[OW-1:0];
		end
		if (rnd_f > SMP_MAXW) begin
			sat_smp = SMP_MAX;
		end else if (rnd_f < SMP_MINW) begin
			sat_smp = SMP_MIN;
		end else begin
			sat_smp = rnd_f[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cos_q <= OSC_ONE;
			step_sin_q <= '0;
			shift_up_q <= 1'b0;
			quarter_q  <= 1'b0;
			osc_i_q    <= '0;
			osc_q_q    <= OSC_ONE;
			qph_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STEP_COS: begin
						step_cos_q <= cfg_data;
						osc_i_q    <= '0;
						osc_q_q    <= OSC_ONE;
					end
					REG_STEP_SIN: begin
						step_sin_q <= cfg_data;
						osc_i_q    <= '0;
						osc_q_q    <= OSC_ONE;
					end
					REG_SHIFT_UP:   shift_up_q <= cfg_data[0];
					REG_QUARTER_FS: quarter_q <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (cmd.wb_sel)
				WB_OUTI: begin
					osc_q_q <= nq_q;
					osc_i_q <= ni_q;
				end
				WB_OSCQ: osc_q_q <= sat_osc;
				WB_OSCI: osc_i_q <= sat_osc;
				default: ;
			endcase
			if (cmd.take) begin
				if (last_in_block) begin
					qph_q <= '0;
				end else if (quarter_q) begin
					qph_q <= qph_q + 2'd1;
				end
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ri_q    <= ri_in;
			rq_q    <= rq_in;
			last_q  <= last_in_block;
			res_i_q <= q_ni;
			res_q_q <= q_nq;
		end
		p_q <= mul_a * mul_b;
		unique case (cmd.acc_op)
			ACC_LOAD:   acc_q <= AW'(p_q);
			ACC_ADD:    acc_q <= acc_q + AW'(p_q);
			ACC_SUB:    acc_q <= acc_q - AW'(p_q);
			ACC_C3_SUB: acc_q <= C3 - AW'(p_q);
			default: ;
		endcase
		unique case (cmd.wb_sel)
			WB_NQ:   nq_q <= sat_osc;
			WB_NI:   ni_q <= sat_osc;
			WB_OUTQ: res_q_q <= sat_smp;
			WB_OUTI: res_i_q <= sat_smp;
			WB_GAIN: g_q <= sat_gain;
			default: ;
		endcase
		if (cmd.out_load) begin
			out_i_q <= shift_up_q ? res_i_q : res_q_q;
			out_q_q <= shift_up_q ? res_q_q : res_i_q;
		end
	end

	assign status.quarter_mode = quarter_q;
	assign status.last         = last_q;
	assign status.out_free     = !m_tvalid_q || m_tready;
	assign m_tvalid            = m_tvalid_q;
	assign out_i               = out_i_q;
	assign out_q               = out_q_q;

endmodule

`default_nettype wire

// File: hw/rtl/iqfs_ctrl.sv
// controller: sequences the shared multiplier, accumulator and writebacks
// depends on iqfs_pkg and iq_frequency_shifter_defines.svh
`default_nettype none

`include "iq_frequency_shifter_defines.svh"

module iqfs_ctrl
	import iqfs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_K0, ST_K1, ST_K2, ST_K3, ST_K4, ST_K5, ST_K6, ST_K7, ST_K8, ST_K9, ST_K10,
		ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5, ST_G6,
		ST_DONE
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd          = '{take: 1'b0, mul_sel: MUL_OQ_C, acc_op: ACC_HOLD,
			wb_sel: WB_NONE, out_load: 1'b0};
		state_d      = state_q;
		s_tready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
				if (s_tvalid) begin
					state_d = status.quarter_mode ? ST_DONE : ST_K0;
				end
			end
			// rotate oscillator
			ST_K0: begin
				cmd.mul_sel = MUL_OQ_C;
				state_d     = ST_K1;
			end
			ST_K1: begin
				cmd.mul_sel = MUL_OI_S;
				cmd.acc_op  = ACC_LOAD;
				state_d     = ST_K2;
			end
			ST_K2: begin
				cmd.mul_sel = MUL_OI_C;
				cmd.acc_op  = ACC_SUB;
				state_d     = ST_K3;
			end
			ST_K3: begin
				cmd.mul_sel = MUL_OQ_S;
				cmd.acc_op  = ACC_LOAD;
				cmd.wb_sel  = WB_NQ;
				state_d     = ST_K4;
			end
			// mix sample
			ST_K4: begin
				cmd.mul_sel = MUL_RQ_NQ;
				cmd.acc_op  = ACC_ADD;
				state_d     = ST_K5;
			end
			ST_K5: begin
				cmd.acc_op = ACC_LOAD;
				cmd.wb_sel = WB_NI;
				state_d    = ST_K6;
			end
			ST_K6: begin
				cmd.mul_sel = MUL_RI_NI;
				state_d     = ST_K7;
			end
			ST_K7: begin
				cmd.mul_sel = MUL_RI_NQ;
				cmd.acc_op  = ACC_SUB;
				state_d     = ST_K8;
			end
			ST_K8: begin
				cmd.mul_sel = MUL_RQ_NI;
				cmd.acc_op  = ACC_LOAD;
				cmd.wb_sel  = WB_OUTQ;
				state_d     = ST_K9;
			end
			ST_K9: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_K10;
			end
			ST_K10: begin
				cmd.mul_sel = MUL_NQ_NQ;
				cmd.wb_sel  = WB_OUTI;
				state_d     = status.last ? ST_G0 : ST_DONE;
			end
			// end-of-block gain correction
			ST_G0: begin
				cmd.mul_sel = MUL_NI_NI;
				cmd.acc_op  = ACC_C3_SUB;
				state_d     = ST_G1;
			end
			ST_G1: begin
				cmd.acc_op = ACC_SUB;
				state_d    = ST_G2;
			end
			ST_G2: begin
				cmd.wb_sel = WB_GAIN;
				state_d    = ST_G3;
			end
			ST_G3: begin
				cmd.mul_sel = MUL_G_NQ;
				state_d     = ST_G4;
			end
			ST_G4: begin
				cmd.mul_sel = MUL_G_NI;
				cmd.acc_op  = ACC_LOAD;
				state_d     = ST_G5;
			end
			ST_G5: begin
				cmd.acc_op = ACC_LOAD;
				cmd.wb_sel = WB_OSCQ;
				state_d    = ST_G6;
			end
			ST_G6: begin
				cmd.wb_sel = WB_OSCI;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				cmd.out_load = status.out_free;
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`IQFS_ASSERT_NEXT(a_take_leaves_idle, s_tvalid && s_tready, state_q != ST_IDLE)
	`IQFS_ASSERT_NEXT(a_last_enters_gain, state_q == ST_K10 && status.last, state_q == ST_G0)
	`IQFS_ASSERT_IMP(a_load_when_free, cmd.out_load, status.out_free && state_q == ST_DONE)

endmodule

`default_nettype wire

// File: hw/rtl/iq_frequency_shifter.sv
// Frequency shifter for I/Q sample streams. Each transfer on the s_ side gives one shifted
// I/Q pair on the m_ side. One shared signed multiplier forms every product in turn, so a
// normal-mode sample runs through the oscillator rotation and mixing states, and also
// through the gain correction states when s_tlast marks the end of a block; quarter-fs
// mode skips both. A new sample is taken once the previous result is in the output
// register. Register writes on the cfg_ channel take effect at once and are to be made
// while no sample is in flight; a step write restarts the oscillator at (0, 1.0).
// top level; depends on iqfs_pkg, iqfs_ctrl and iqfs_datapath
`default_nettype none

module iq_frequency_shifter
	import iqfs_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int OSC_WIDTH    = OSC_WIDTH_DEF,
	parameter int TDATA_WIDTH  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [TDATA_WIDTH-1:0]     s_tdata,   // sample_i, sample_q, zero pad
	input  wire logic                       s_tlast,   // last_in_block
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [TDATA_WIDTH-1:0]          m_tdata,   // out_i, out_q, zero pad
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [OSC_WIDTH-1:0]       cfg_data
);

	ctrl_cmd_t                        cmd;
	dp_status_t                       status;
	logic signed [SAMPLE_WIDTH-1:0]   out_i, out_q;

	assign cfg_ready = 1'b1;

	iqfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	iqfs_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.OSC_WIDTH    (OSC_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.sample_i      (signed'(s_tdata[SAMPLE_WIDTH-1:0])),
		.sample_q      (signed'(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
		.last_in_block (s_tlast),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.out_i         (out_i),
		.out_q         (out_q)
	);

	assign m_tdata = TDATA_WIDTH'({out_q, out_i});

endmodule

`default_nettype wire
